// ----- rtl/mer_pkg.sv -----
package mer_pkg;

    // default field widths
    localparam int CENTER_BITS_DEF = 11;
    localparam int RADIUS_BITS_DEF = 10;

    // opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // drawing phase
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_R1   = 2'd1;
    localparam logic [1:0] PH_R2   = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // region tag on each point
    localparam logic REGION_ONE = 1'b0;
    localparam logic REGION_TWO = 1'b1;

endpackage

// ----- rtl/midpoint_ellipse_rasterizer_core.sv -----
// Midpoint ellipse rasterizer. A start beat (opcode 0) loads the centre and both
// semi-axes; the block squares the radii and forms the first decision value on
// one shared registered multiplier, emits nothing, and then checks the region
// bounds before it is ready again (a zero radius sends it straight on into the
// region-two rebuild first). Each step beat
// (opcode 1) returns four result beats, the symmetric points (+x,+y), (-x,+y),
// (+x,-y), (-x,-y) of the current position tagged with the region, then advances
// the position. A step accepts the beat and advances, checks the region
// bounds, then loads the output register one point per cycle while the result
// side does not stall. On the step that crosses from region one into region two
// the region-two decision value is first rebuilt, one multiplier product per
// cycle, before the points go out. The fourth point of the final step carries
// last; later steps return nothing until the next start. A start beat during a
// drawing abandons it.
module midpoint_ellipse_rasterizer_core #(
    parameter int CENTER_BITS = mer_pkg::CENTER_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [CENTER_BITS-1:0]        s_center_x,
    input  logic [CENTER_BITS-1:0]        s_center_y,
    input  logic [RADIUS_BITS-1:0]        s_radius_x,
    input  logic [RADIUS_BITS-1:0]        s_radius_y,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [CENTER_BITS+1:0] m_point_x,
    output logic signed [CENTER_BITS+1:0] m_point_y,
    output logic                          m_region,
    output logic                          m_last
);

    // widths derived from the field widths
    localparam int RB  = RADIUS_BITS;
    localparam int CB  = CENTER_BITS;
    localparam int XW  = RB + 1;               // position offsets, one bit of headroom
    localparam int SQW = 2 * RB;               // squared radii
    localparam int MAW = 2 * RB;               // multiplier operand a
    localparam int MBW = 2 * RB + 4;           // multiplier operand b, holds (2x+1)^2
    localparam int PRW = MAW + MBW;            // product register
    localparam int SLW = 3 * RB + 3;           // signed slope terms
    localparam int DW  = 4 * RB + 8;           // signed decision / accumulator
    localparam int PW  = CB + 2;               // output point width
    localparam int SW  = ((XW > CB) ? XW : CB) + 2;  // point arithmetic before wrap

    // sequencer codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQX   = 4'd1;   // rx*rx
    localparam logic [3:0] ST_SQY   = 4'd2;   // ry*ry
    localparam logic [3:0] ST_RXRY  = 4'd3;   // rx^2*ry
    localparam logic [3:0] ST_INIT  = 4'd4;   // first decision value
    localparam logic [3:0] ST_CHECK = 4'd5;   // region bounds
    localparam logic [3:0] ST_R2A   = 4'd6;   // ry^2*(2x+1)^2
    localparam logic [3:0] ST_R2B   = 4'd7;   // (y-1)^2
    localparam logic [3:0] ST_R2C   = 4'd8;   // rx^2*(y-1)^2
    localparam logic [3:0] ST_R2D   = 4'd9;   // rx^2*ry^2
    localparam logic [3:0] ST_R2E   = 4'd10;  // region-two decision value
    localparam logic [3:0] ST_EMIT  = 4'd11;  // four points into the output register

    logic [3:0]              state_reg, state_next;
    logic [1:0]              phase_reg, phase_next;
    logic [CB-1:0]           cx_reg, cx_next;
    logic [CB-1:0]           cy_reg, cy_next;
    logic [RB-1:0]           rx_reg, rx_next;
    logic [RB-1:0]           ry_reg, ry_next;
    logic [XW-1:0]           ofx_reg, ofx_next;
    logic signed [XW-1:0]    ofy_reg, ofy_next;
    logic [SQW-1:0]          rxsq_reg, rxsq_next;
    logic [SQW-1:0]          rysq_reg, rysq_next;
    logic signed [SLW-1:0]   spx_reg, spx_next;
    logic signed [SLW-1:0]   spy_reg, spy_next;
    logic signed [DW-1:0]    dec_reg, dec_next;
    logic signed [DW-1:0]    acc_reg, acc_next;
    logic [PRW-1:0]          prod_reg;
    logic [XW-1:0]           ptx_reg, ptx_next;
    logic signed [XW-1:0]    pty_reg, pty_next;
    logic                    tag_reg, tag_next;
    logic                    emit_reg, emit_next;
    logic [1:0]              idx_reg, idx_next;

    logic                    m_valid_reg, m_valid_next;
    logic signed [PW-1:0]    m_point_x_reg, m_point_x_next;
    logic signed [PW-1:0]    m_point_y_reg, m_point_y_next;
    logic                    m_region_reg, m_region_next;
    logic                    m_last_reg, m_last_next;

    // shared multiplier operands
    logic [MAW-1:0]          mul_a;
    logic [MBW-1:0]          mul_b;

    // datapath helpers
    logic signed [DW-1:0]    rxsq_d, rysq_d, prod_d;
    logic signed [SLW-1:0]   rysq2, rxsq2, npx, npy;
    logic signed [DW-1:0]    dec_r1, dec_r2, s_init, s_r2;
    logic [XW:0]             x2p1;
    logic signed [XW:0]      ym;
    logic [XW:0]             ym_abs;
    logic                    in_beat, out_free;
    logic signed [SW-1:0]    cx_s, cy_s, x_s, y_s, px_full, py_full;

    // divide by four, truncating toward zero
    function automatic logic signed [DW-1:0] quarter(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] bias;
        bias = v[DW-1] ? DW'(3) : DW'(0);
        return (v + bias) >>> 2;
    endfunction

    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign rxsq_d = signed'(DW'(rxsq_reg));
    assign rysq_d = signed'(DW'(rysq_reg));
    assign prod_d = signed'(DW'(prod_reg));

    // per-step increments
    assign rysq2 = signed'(SLW'({rysq_reg, 1'b0}));
    assign rxsq2 = signed'(SLW'({rxsq_reg, 1'b0}));
    assign npx   = spx_reg + rysq2;
    assign npy   = spy_reg - rxsq2;

    // region one: x always moves, y moves when the decision is not negative
    assign dec_r1 = dec_reg + rysq_d + DW'(npx) - (dec_reg[DW-1] ? DW'(0) : DW'(npy));
    // region two: y always moves, x moves when the decision is not positive
    assign dec_r2 = dec_reg + rxsq_d - DW'(npy)
                  + ((dec_reg > DW'(0)) ? DW'(0) : DW'(npx));

    // 4*ry^2 - 4*rx^2*ry + rx^2, with rx^2*ry in the product register
    assign s_init = (rysq_d <<< 2) - (prod_d <<< 2) + rxsq_d;
    // accumulated terms minus 4*rx^2*ry^2
    assign s_r2   = acc_reg - (prod_d <<< 2);

    assign x2p1   = {ofx_reg, 1'b1};
    assign ym     = (XW + 1)'(ofy_reg) - (XW + 1)'(1);
    assign ym_abs = ym[XW] ? unsigned'(-ym) : unsigned'(ym);

    // point arithmetic, wrapped to the output width
    assign cx_s    = signed'(SW'(cx_reg));
    assign cy_s    = signed'(SW'(cy_reg));
    assign x_s     = signed'(SW'(ptx_reg));
    assign y_s     = SW'(pty_reg);
    assign px_full = idx_reg[0] ? (cx_s - x_s) : (cx_s + x_s);
    assign py_full = idx_reg[1] ? (cy_s - y_s) : (cy_s + y_s);

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX: begin
                mul_a = MAW'(rx_reg);
                mul_b = MBW'(rx_reg);
            end
            ST_SQY: begin
                mul_a = MAW'(ry_reg);
                mul_b = MBW'(ry_reg);
            end
            ST_RXRY: begin
                mul_a = rxsq_reg;
                mul_b = MBW'(ry_reg);
            end
            ST_CHECK: begin
                mul_a = MAW'(x2p1);
                mul_b = MBW'(x2p1);
            end
            ST_R2A: begin
                mul_a = rysq_reg;
                mul_b = prod_reg[MBW-1:0];
            end
            ST_R2B: begin
                mul_a = MAW'(ym_abs);
                mul_b = MBW'(ym_abs);
            end
            ST_R2C: begin
                mul_a = rxsq_reg;
                mul_b = prod_reg[MBW-1:0];
            end
            ST_R2D: begin
                mul_a = rxsq_reg;
                mul_b = MBW'(rysq_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer and datapath next state
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        ofx_next       = ofx_reg;
        ofy_next       = ofy_reg;
        rxsq_next      = rxsq_reg;
        rysq_next      = rysq_reg;
        spx_next       = spx_reg;
        spy_next       = spy_reg;
        dec_next       = dec_reg;
        acc_next       = acc_reg;
        ptx_next       = ptx_reg;
        pty_next       = pty_reg;
        tag_next       = tag_reg;
        emit_next      = emit_reg;
        idx_next       = idx_reg;
        m_valid_next   = m_valid_reg;
        m_point_x_next = m_point_x_reg;
        m_point_y_next = m_point_y_reg;
        m_region_next  = m_region_reg;
        m_last_next    = m_last_reg;

        // output register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    if (s_opcode == mer_pkg::OP_START) begin
                        cx_next    = s_center_x;
                        cy_next    = s_center_y;
                        rx_next    = s_radius_x;
                        ry_next    = s_radius_y;
                        ofx_next   = '0;
                        ofy_next   = signed'(XW'(s_radius_y));
                        spx_next   = '0;
                        phase_next = mer_pkg::PH_R1;
                        emit_next  = 1'b0;
                        state_next = ST_SQX;
                    end else if (phase_reg == mer_pkg::PH_R1 ||
                                 phase_reg == mer_pkg::PH_R2) begin
                        // keep the pre-step position for the points
                        ptx_next  = ofx_reg;
                        pty_next  = ofy_reg;
                        tag_next  = (phase_reg == mer_pkg::PH_R2) ?
                                    mer_pkg::REGION_TWO : mer_pkg::REGION_ONE;
                        emit_next = 1'b1;
                        if (phase_reg == mer_pkg::PH_R1) begin
                            ofx_next = ofx_reg + XW'(1);
                            spx_next = npx;
                            dec_next = dec_r1;
                            if (!dec_reg[DW-1]) begin
                                ofy_next = ofy_reg - XW'(1);
                                spy_next = npy;
                            end
                        end else begin
                            ofy_next = ofy_reg - XW'(1);
                            spy_next = npy;
                            dec_next = dec_r2;
                            if (!(dec_reg > DW'(0))) begin
                                ofx_next = ofx_reg + XW'(1);
                                spx_next = npx;
                            end
                        end
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_SQX: begin
                state_next = ST_SQY;
            end
            ST_SQY: begin
                rxsq_next  = prod_reg[SQW-1:0];
                state_next = ST_RXRY;
            end
            ST_RXRY: begin
                rysq_next  = prod_reg[SQW-1:0];
                state_next = ST_INIT;
            end
            ST_INIT: begin
                spy_next   = signed'(SLW'({prod_reg[3*RB-1:0], 1'b0}));
                dec_next   = quarter(s_init);
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (phase_reg == mer_pkg::PH_R1 && !(spx_reg < spy_reg)) begin
                    // region one over: rebuild the decision value here
                    state_next = ST_R2A;
                end else begin
                    if (phase_reg == mer_pkg::PH_R2 && ofy_reg[XW-1]) begin
                        phase_next = mer_pkg::PH_DONE;
                    end
                    idx_next   = '0;
                    state_next = emit_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_R2A: begin
                state_next = ST_R2B;
            end
            ST_R2B: begin
                acc_next   = prod_d;
                state_next = ST_R2C;
            end
            ST_R2C: begin
                state_next = ST_R2D;
            end
            ST_R2D: begin
                acc_next   = acc_reg + (prod_d <<< 2);
                state_next = ST_R2E;
            end
            ST_R2E: begin
                dec_next   = quarter(s_r2);
                phase_next = mer_pkg::PH_R2;
                state_next = ST_CHECK;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_point_x_next = px_full[PW-1:0];
                    m_point_y_next = py_full[PW-1:0];
                    m_region_next  = tag_reg;
                    m_last_next    = (idx_reg == 2'd3) && (phase_reg == mer_pkg::PH_DONE);
                    idx_next       = idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= mer_pkg::PH_IDLE;
            m_valid_reg <= 1'b0;
            emit_reg    <= 1'b0;
            idx_reg     <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            ofx_reg     <= '0;
            ofy_reg     <= '0;
            rxsq_reg    <= '0;
            rysq_reg    <= '0;
            spx_reg     <= '0;
            spy_reg     <= '0;
            dec_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            emit_reg    <= emit_next;
            idx_reg     <= idx_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            ofx_reg     <= ofx_next;
            ofy_reg     <= ofy_next;
            rxsq_reg    <= rxsq_next;
            rysq_reg    <= rysq_next;
            spx_reg     <= spx_next;
            spy_reg     <= spy_next;
            dec_reg     <= dec_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        rx_reg         <= rx_next;
        ry_reg         <= ry_next;
        acc_reg        <= acc_next;
        prod_reg       <= mul_a * mul_b;
        ptx_reg        <= ptx_next;
        pty_reg        <= pty_next;
        tag_reg        <= tag_next;
        m_point_x_reg  <= m_point_x_next;
        m_point_y_reg  <= m_point_y_next;
        m_region_reg   <= m_region_next;
        m_last_reg     <= m_last_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_point_x = m_point_x_reg;
    assign m_point_y = m_point_y_reg;
    assign m_region  = m_region_reg;
    assign m_last    = m_last_reg;

    // once loaded, an ellipse never drops back to the unloaded phase
    a_phase_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != mer_pkg::PH_IDLE |=> phase_reg != mer_pkg::PH_IDLE)
        else $error("phase returned to idle");

    // resting in region one means the slope test still holds
    a_r1_slope: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && phase_reg == mer_pkg::PH_R1) |-> (spx_reg < spy_reg))
        else $error("region one left unsettled");

    // resting in region two means y has not run past zero
    a_r2_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && phase_reg == mer_pkg::PH_R2) |-> !ofy_reg[XW-1])
        else $error("region two left unsettled");

    // a point beat is only loaded while emitting
    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && m_valid_next) |-> state_reg == ST_EMIT)
        else $error("point loaded outside emission");

endmodule
